FILE: hw/rtl/swan_pkg.sv
// Package for the sensor weighted average normaliser.
// Holds the default sizes, mode codes, output constants and the lane control struct.
// Used by swan_lane and sensor_weighted_average_normalizer.
`timescale 1ns / 1ps

package swan_pkg;

   localparam int unsigned CHANNELS_DEFAULT    = 6;
   localparam int unsigned WINDOW_DEFAULT      = 10;
   localparam int unsigned SAMPLE_BITS_DEFAULT = 10;

   localparam int unsigned MODE_BITS  = 2;
   localparam int unsigned LEVEL_BITS = 8;
   localparam int unsigned SCAN_BITS  = 16;
   localparam int unsigned PERCENT    = 100;
   localparam int unsigned LEVEL_CAP  = 255;
   localparam int unsigned SCAN_RESET = 100;

   localparam logic [MODE_BITS-1:0] MODE_PRIME     = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CALIBRATE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_RUN       = 2'd2;

   typedef struct packed {
      logic                 shift;
      logic                 mean_take;
      logic                 range_load;
      logic                 level_start;
      logic                 level_take;
      logic [MODE_BITS-1:0] mode;
   } lane_ctl_type;

endpackage

FILE: hw/rtl/swan_div.sv
// Restoring divider that produces one quotient bit per cycle.
// Takes a partial remainder below the divisor and shifts in the dividend bits.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module swan_div #(
   parameter int unsigned RW = 10,
   parameter int unsigned N  = 10
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [RW-1:0] rem_init,
   input  logic [N-1:0]  dividend,
   input  logic [RW-1:0] divisor,
   output logic          done,
   output logic [N-1:0]  quotient
);

   localparam int unsigned CW = $clog2(N + 1);

   logic [RW-1:0] rem_ff;
   logic [N-1:0]  dvd_ff;
   logic [RW-1:0] dvs_ff;
   logic [N-1:0]  quo_ff;
   logic [CW-1:0] cnt_ff;
   logic          done_ff;

   logic [RW:0]   trial;
   logic          fit;
   logic [RW-1:0] rem_in;

   always_comb begin
      trial  = {rem_ff, dvd_ff[N-1]};
      fit    = trial >= {1'b0, dvs_ff};
      rem_in = fit ? RW'(trial - {1'b0, dvs_ff}) : trial[RW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff <= rem_init;
            dvd_ff <= dividend;
            dvs_ff <= divisor;
            cnt_ff <= CW'(N);
         end else if (cnt_ff != '0) begin
            rem_ff  <= rem_in;
            dvd_ff  <= dvd_ff << 1;
            quo_ff  <= {quo_ff[N-2:0], fit};
            cnt_ff  <= cnt_ff - 1'b1;
            done_ff <= (cnt_ff == CW'(1));
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hw/rtl/swan_lane.sv
// One channel lane: sample window, running weighted sum, min/max pair and level.
// Forms the mean by reciprocal multiplication and the level with one swan_div.
// Depends on swan_pkg and swan_div.
`timescale 1ns / 1ps

module swan_lane #(
   parameter int unsigned WINDOW      = 10,
   parameter int unsigned SAMPLE_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  swan_pkg::lane_ctl_type            ctl,
   input  logic [SAMPLE_BITS-1:0]            sample,
   output logic [swan_pkg::LEVEL_BITS-1:0]   level,
   output logic                              div_done
);

   import swan_pkg::*;

   localparam int unsigned WSUM = WINDOW * (WINDOW + 1) / 2;
   localparam int unsigned WSB  = $clog2(WSUM + 1);
   localparam int unsigned SW   = SAMPLE_BITS + WSB;
   localparam int unsigned PW   = SAMPLE_BITS + $clog2(WINDOW + 1);
   localparam int unsigned RW   = (SAMPLE_BITS > WSB) ? SAMPLE_BITS : WSB;
   localparam int unsigned NW   = SAMPLE_BITS + $clog2(PERCENT + 1);
   localparam int unsigned RK   = SW + $clog2(WSUM);
   localparam int unsigned PRW  = 2 * SW + 1;
   localparam longint unsigned RECIP =
      ((64'd1 << RK) + 64'(WSUM) - 64'd1) / 64'(WSUM);

   logic [SAMPLE_BITS-1:0] win_ff [WINDOW];
   logic [SW-1:0]          wsum_ff, wsum_in;
   logic [PW-1:0]          psum_ff, psum_in;
   logic [PRW-1:0]         mean_prod;
   logic [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic [SAMPLE_BITS-1:0] min_ff, min_in;
   logic [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [NW-1:0]          num_ff, num_in;
   logic [SAMPLE_BITS-1:0] span_ff, span_in;
   logic                   zero_ff, zero_in;
   logic                   ovf_ff, ovf_in;
   logic [LEVEL_BITS-1:0]  level_ff;

   logic                   div_start;
   logic [RW-1:0]          div_rem;
   logic [SAMPLE_BITS-1:0] div_dvd;
   logic [RW-1:0]          div_dvs;
   logic [SAMPLE_BITS-1:0] div_quo;

   // The weighted sum follows from the old sum minus the plain sum plus the
   // newest sample at full weight, so no pass over the window is needed.
   always_comb begin
      wsum_in = wsum_ff - SW'(psum_ff) + SW'(sample) * SW'(WINDOW);
      psum_in = psum_ff - PW'(win_ff[WINDOW-1]) + PW'(sample);
   end

   // The reciprocal is rounded up, and its excess stays below the weight total,
   // so the truncated quotient is exact for every sum that fits the sum register.
   always_comb begin
      mean_prod = PRW'(wsum_ff) * PRW'(RECIP);
      mean_in   = mean_prod[RK +: SAMPLE_BITS];
   end

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      case (ctl.mode)
         MODE_PRIME: begin
            min_in = mean_in;
            max_in = mean_in;
         end
         MODE_CALIBRATE: begin
            if (mean_in > max_ff) begin
               max_in = mean_in;
            end else if (mean_in < min_ff) begin
               min_in = mean_in;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      zero_in = (max_ff <= min_ff) || (mean_ff <= min_ff);
      span_in = max_ff - min_ff;
      num_in  = NW'(mean_ff - min_ff) * NW'(PERCENT);
      ovf_in  = SAMPLE_BITS'(num_in[NW-1:LEVEL_BITS]) >= span_in;
   end

   always_comb begin
      div_start = ctl.level_start;
      div_rem   = RW'(num_ff[NW-1:SAMPLE_BITS]);
      div_dvd   = num_ff[SAMPLE_BITS-1:0];
      div_dvs   = RW'(span_ff);
   end

   swan_div #(
      .RW (RW),
      .N  (SAMPLE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .rem_init (div_rem),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW; k++) begin
            win_ff[k] <= '0;
         end
         wsum_ff <= '0;
         psum_ff <= '0;
         min_ff  <= '0;
         max_ff  <= '0;
      end else begin
         if (ctl.shift) begin
            for (int k = 1; k < WINDOW; k++) begin
               win_ff[k] <= win_ff[k-1];
            end
            win_ff[0] <= sample;
            wsum_ff   <= wsum_in;
            psum_ff   <= psum_in;
         end
         if (ctl.mean_take) begin
            mean_ff <= mean_in;
            min_ff  <= min_in;
            max_ff  <= max_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.range_load) begin
         num_ff  <= num_in;
         span_ff <= span_in;
         zero_ff <= zero_in;
         ovf_ff  <= ovf_in;
      end
      if (ctl.level_take) begin
         if (zero_ff) begin
            level_ff <= '0;
         end else if (ovf_ff) begin
            level_ff <= LEVEL_BITS'(LEVEL_CAP);
         end else begin
            level_ff <= div_quo[LEVEL_BITS-1:0];
         end
      end
   end

   assign level = level_ff;

endmodule

FILE: hw/rtl/sensor_weighted_average_normalizer.sv
// Top level of the sensor weighted average normaliser: sequencer, scan countdown,
// one swan_lane per channel and the merging output register.
// Depends on swan_pkg and swan_lane.
//
//   Channel  Direction  Ports                      Content
//   req      in         req_tvalid/tready/tdata/tuser   samples; mode
//   rsp      out        rsp_tvalid/tready/tdata/tuser   levels; scan done flag
//   csr      in         csr_we/csr_wdata           scan count
//
// An item passes through these steps in order: accept it, form the mean, latch the range,
// start the divider, wait for the per-lane level divider to finish, take the level and
// load the result into the output register once that register is free.
// Reset is synchronous and active high; it clears the windows, min/max, and reloads
// the scan count with 100. A result waiting on rsp does not block the next item;
// only a second finished result waits until the first has been taken.
`timescale 1ns / 1ps

module sensor_weighted_average_normalizer #(
   parameter int unsigned CHANNELS    = swan_pkg::CHANNELS_DEFAULT,
   parameter int unsigned WINDOW      = swan_pkg::WINDOW_DEFAULT,
   parameter int unsigned SAMPLE_BITS = swan_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // sample_0, sample_1, ... from the lowest bit, zero padding to whole bytes
   input  logic [((CHANNELS*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // mode
   input  logic [swan_pkg::MODE_BITS-1:0]           req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // level_0, level_1, ... from the lowest bit
   output logic [CHANNELS*swan_pkg::LEVEL_BITS-1:0] rsp_tdata,
   // scan_done
   output logic [0:0]                               rsp_tuser,
   input  logic                                     csr_we,
   input  logic [swan_pkg::SCAN_BITS-1:0]           csr_wdata
);

   import swan_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MEAN,
      S_RANGE,
      S_LEVEL_GO,
      S_LEVEL_WAIT,
      S_DONE
   } state_type;

   state_type                       state_ff;
   logic [MODE_BITS-1:0]            mode_ff;
   logic [SCAN_BITS-1:0]            scan_left_ff;
   logic                            scan_finished_ff;
   logic                            rsp_tvalid_ff;
   logic [CHANNELS*LEVEL_BITS-1:0]  rsp_tdata_ff;
   logic                            rsp_tuser_ff;

   lane_ctl_type                    ctl;
   logic                            accept;
   logic                            all_done;
   logic                            out_free;
   logic [CHANNELS-1:0]             done_vec;
   logic [LEVEL_BITS-1:0]           level_vec [CHANNELS];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign all_done   = &done_vec;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      ctl.shift       = accept;
      ctl.mean_take   = (state_ff == S_MEAN);
      ctl.range_load  = (state_ff == S_RANGE);
      ctl.level_start = (state_ff == S_LEVEL_GO);
      ctl.level_take  = (state_ff == S_LEVEL_WAIT) && all_done;
      ctl.mode        = mode_ff;
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      swan_lane #(
         .WINDOW      (WINDOW),
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .sample   (req_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]),
         .level    (level_vec[c]),
         .div_done (done_vec[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         scan_left_ff     <= SCAN_BITS'(SCAN_RESET);
         scan_finished_ff <= 1'b0;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         if ((state_ff == S_DONE) && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (csr_we) begin
            scan_left_ff     <= csr_wdata;
            scan_finished_ff <= 1'b0;
         end else if (accept && (req_tuser == MODE_CALIBRATE)) begin
            if (scan_left_ff != '0) begin
               scan_left_ff <= scan_left_ff - 1'b1;
            end
            if (scan_left_ff <= SCAN_BITS'(1)) begin
               scan_finished_ff <= 1'b1;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  mode_ff  <= req_tuser;
                  state_ff <= S_MEAN;
               end
            end
            S_MEAN: begin
               state_ff <= S_RANGE;
            end
            S_RANGE: begin
               state_ff <= S_LEVEL_GO;
            end
            S_LEVEL_GO: begin
               state_ff <= S_LEVEL_WAIT;
            end
            S_LEVEL_WAIT: begin
               if (all_done) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  for (int c = 0; c < CHANNELS; c++) begin
                     rsp_tdata_ff[c*LEVEL_BITS +: LEVEL_BITS] <= level_vec[c];
                  end
                  rsp_tuser_ff <= scan_finished_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid   = rsp_tvalid_ff;
   assign rsp_tdata    = rsp_tdata_ff;
   assign rsp_tuser[0] = rsp_tuser_ff;

`ifndef SYNTH
   a_one_item_at_a_time : assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("item accepted while another is in progress");

   a_lanes_in_step : assert property (@(posedge clock) disable iff (reset)
      (&done_vec) == (|done_vec))
      else $error("lane dividers finished out of step");

   a_csr_clears_done : assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !scan_finished_ff)
      else $error("scan count write did not clear the finished flag");

   a_done_holds : assert property (@(posedge clock) disable iff (reset)
      scan_finished_ff && !csr_we |=> scan_finished_ff)
      else $error("scan finished flag dropped without a register write");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && rsp_tvalid)
      else $error("waiting result was overwritten");
`endif

endmodule
